FILE: rtl/cwf_pkg.sv
// Package for the comment and whitespace filter.
// Holds the one-hot scanner mode type, the character constants,
// and the request structs shared by the step logic, result queue and top level.
package cwf_pkg;

    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned QUEUE_DEPTH_D = 4;

    localparam logic [BYTE_W-1:0] CH_QUOTE     = 8'h22;
    localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_APOS      = 8'h27;
    localparam logic [BYTE_W-1:0] CH_SLASH     = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_STAR      = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_LF        = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR        = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_TAB       = 8'h09;
    localparam logic [BYTE_W-1:0] CH_SPACE     = 8'h20;

    typedef enum logic [6:0] {
        MODE_NORMAL = 7'b0000001,
        MODE_STRING = 7'b0000010,
        MODE_RUN    = 7'b0000100,
        MODE_SLASH  = 7'b0001000,
        MODE_LINE   = 7'b0010000,
        MODE_BLOCK  = 7'b0100000,
        MODE_STAR   = 7'b1000000
    } mode_t;

    typedef struct packed {
        mode_t             mode;
        logic              resume_in_run;
        logic [BYTE_W-1:0] previous_byte;
    } scan_state_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last_of_run;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    item1;
        result_t    item0;
    } push_req_t;

    function automatic logic is_space_byte(input logic [BYTE_W-1:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
    endfunction

endpackage

FILE: rtl/cwf_step.sv
// Per-byte scanner step for the comment and whitespace filter.
// Pure combinational: current state plus one input byte gives the next
// state and up to two result bytes. Depends on cwf_pkg.
module cwf_step
    import cwf_pkg::*;
(
    input  scan_state_t       state_cur,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic              stream_end,
    output scan_state_t       state_next,
    output push_req_t         push
);

    logic              plain_emit;
    logic [BYTE_W-1:0] plain_byte;
    mode_t             plain_mode;
    logic              b_space;

    always_comb begin
        b_space    = is_space_byte(in_byte);
        plain_emit = 1'b1;
        plain_byte = in_byte;
        plain_mode = MODE_NORMAL;
        if (in_byte == CH_QUOTE) begin
            plain_mode = (state_cur.previous_byte != CH_APOS) ? MODE_STRING : MODE_NORMAL;
        end else if (in_byte == CH_SLASH) begin
            plain_emit = 1'b0;
            plain_mode = MODE_SLASH;
        end else if (b_space) begin
            plain_byte = CH_SPACE;
            plain_mode = MODE_RUN;
        end
    end

    logic [BYTE_W-1:0] out_arr [2];
    logic [1:0]        n;
    mode_t             mode_n;
    logic              resume_n;

    always_comb begin
        out_arr[0] = '0;
        out_arr[1] = '0;
        n          = 2'd0;
        mode_n     = state_cur.mode;
        resume_n   = state_cur.resume_in_run;

        case (state_cur.mode)
            MODE_STRING: begin
                out_arr[n[0]] = in_byte;
                n = n + 2'd1;
                if (in_byte == CH_QUOTE && state_cur.previous_byte != CH_BACKSLASH) begin
                    mode_n = MODE_NORMAL;
                end
            end
            MODE_RUN: begin
                if (b_space) begin
                    mode_n = MODE_RUN;
                end else if (in_byte == CH_SLASH) begin
                    mode_n   = MODE_SLASH;
                    resume_n = 1'b1;
                end else begin
                    if (plain_emit) begin
                        out_arr[n[0]] = plain_byte;
                        n = n + 2'd1;
                    end
                    mode_n = plain_mode;
                end
            end
            MODE_SLASH: begin
                if (in_byte == CH_SLASH) begin
                    mode_n = MODE_LINE;
                end else if (in_byte == CH_STAR) begin
                    mode_n = MODE_BLOCK;
                end else begin
                    out_arr[n[0]] = CH_SLASH;
                    n = n + 2'd1;
                    resume_n = 1'b0;
                    if (plain_emit) begin
                        out_arr[n[0]] = plain_byte;
                        n = n + 2'd1;
                    end
                    mode_n = plain_mode;
                end
            end
            MODE_LINE: begin
                if (in_byte == CH_LF) begin
                    mode_n   = state_cur.resume_in_run ? MODE_RUN : MODE_NORMAL;
                    resume_n = 1'b0;
                end
            end
            MODE_BLOCK: begin
                if (in_byte == CH_STAR) begin
                    mode_n = MODE_STAR;
                end
            end
            MODE_STAR: begin
                if (in_byte == CH_SLASH) begin
                    mode_n   = state_cur.resume_in_run ? MODE_RUN : MODE_NORMAL;
                    resume_n = 1'b0;
                end else if (in_byte != CH_STAR) begin
                    mode_n = MODE_BLOCK;
                end
            end
            default: begin
                if (plain_emit) begin
                    out_arr[n[0]] = plain_byte;
                    n = n + 2'd1;
                end
                if (in_byte == CH_SLASH) begin
                    resume_n = 1'b0;
                end
                mode_n = plain_mode;
            end
        endcase

        // flush a held slash and return to reset state
        if (stream_end) begin
            if (mode_n == MODE_SLASH) begin
                out_arr[n[0]] = CH_SLASH;
                n = n + 2'd1;
            end
            state_next.mode          = MODE_NORMAL;
            state_next.resume_in_run = 1'b0;
            state_next.previous_byte = '0;
        end else begin
            state_next.mode          = mode_n;
            state_next.resume_in_run = resume_n;
            state_next.previous_byte = in_byte;
        end

        push.count             = n;
        push.item0.out_byte    = out_arr[0];
        push.item0.last_of_run = (n == 2'd1);
        push.item1.out_byte    = out_arr[1];
        push.item1.last_of_run = 1'b1;
    end

endmodule

FILE: rtl/cwf_out_queue.sv
// Result queue for the comment and whitespace filter.
// Takes up to two results per cycle and releases one per cycle on the
// master stream side while m_ready is high. Depends on cwf_pkg.
module cwf_out_queue
    import cwf_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_D
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  push_req_t                         push,
    output logic                              room,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]  level,
    output logic                              m_valid,
    output result_t                           m_item,
    input  logic                              m_ready
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    result_t           entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [PTR_W-1:0]  tail_plus1;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              pop;

    assign pop        = m_valid && m_ready;
    assign m_valid    = (count_reg != '0);
    assign m_item     = entry_reg[head_reg];
    assign room       = (count_reg <= CNT_W'(QUEUE_DEPTH - 2));
    assign level      = count_reg;
    assign tail_plus1 = (tail_reg == PTR_LAST) ? '0 : tail_reg + PTR_W'(1);

    always_comb begin
        head_next = head_reg;
        if (pop) begin
            head_next = (head_reg == PTR_LAST) ? '0 : head_reg + PTR_W'(1);
        end
        case (push.count)
            2'd1:    tail_next = tail_plus1;
            2'd2:    tail_next = (tail_plus1 == PTR_LAST) ? '0 : tail_plus1 + PTR_W'(1);
            default: tail_next = tail_reg;
        endcase
        count_next = count_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            entry_reg[tail_reg] <= push.item0;
        end
        if (push.count == 2'd2) begin
            entry_reg[tail_plus1] <= push.item1;
        end
    end

endmodule

FILE: rtl/c_comment_whitespace_filter.sv
// Top level of the C comment stripper with whitespace collapse.
// Holds the scanner state registers; instantiates cwf_step and cwf_out_queue.
// Depends on cwf_pkg.
//
//  channel  | dir | tdata          | tlast        | tuser
//  ---------+-----+----------------+--------------+------
//  s_axis   | in  | [7:0] in_byte  | stream_end   | -
//  m_axis   | out | [7:0] out_byte | last_of_run  | -
//
// One request per cycle is taken while the result queue has room for two
// results; results are registered in the queue and leave it one per cycle
// while m_axis_tready is high. A request with two results needs two transfers,
// so the queue depth and the master side rate set the sustained input rate.
// Reset (aresetn low, synchronous) clears scanner state and empties the queue.
// A stall on m_axis backs up into s_axis_tready once the queue fills.
module c_comment_whitespace_filter
    import cwf_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_D
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [BYTE_W-1:0] s_axis_tdata,   // [7:0] in_byte
    input  logic              s_axis_tlast,   // stream_end
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [BYTE_W-1:0] m_axis_tdata,   // [7:0] out_byte
    output logic              m_axis_tlast    // last_of_run
);

    scan_state_t state_reg, state_next, step_next;
    push_req_t   step_push, push;
    result_t     q_item;
    logic        q_room;
    logic        accept;
    logic [$clog2(QUEUE_DEPTH+1)-1:0] q_level;

    assign s_axis_tready = q_room;
    assign accept        = s_axis_tvalid && s_axis_tready;

    cwf_step u_step (
        .state_cur  (state_reg),
        .in_byte    (s_axis_tdata),
        .stream_end (s_axis_tlast),
        .state_next (step_next),
        .push       (step_push)
    );

    always_comb begin
        state_next = state_reg;
        push       = '0;
        if (accept) begin
            state_next = step_next;
            push       = step_push;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.mode          <= MODE_NORMAL;
            state_reg.resume_in_run <= 1'b0;
            state_reg.previous_byte <= '0;
        end else begin
            state_reg <= state_next;
        end
    end

    cwf_out_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_out_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .room    (q_room),
        .level   (q_level),
        .m_valid (m_axis_tvalid),
        .m_item  (q_item),
        .m_ready (m_axis_tready)
    );

    assign m_axis_tdata = q_item.out_byte;
    assign m_axis_tlast = q_item.last_of_run;

    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_level <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
        else $error("result queue overflow");

    a_end_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_axis_tlast |=> state_reg.mode == MODE_NORMAL &&
            !state_reg.resume_in_run && state_reg.previous_byte == '0)
        else $error("scanner state not cleared after stream end");

    a_double_from_slash: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && step_push.count == 2'd2 |-> state_reg.mode == MODE_SLASH)
        else $error("two results outside held slash");

    a_string_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && state_reg.mode == MODE_STRING |-> step_push.count != 2'd0)
        else $error("byte inside string dropped");

    a_valid_level: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid == (q_level != '0))
        else $error("output valid disagrees with queue level");

endmodule
